// File: src/lprd_pkg.sv
`default_nettype none

package lprd_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CountW-1:0] CountMax = '1;

	localparam logic [CountW-1:0] BootGuardReset = 16'd3000;
	localparam logic [CountW-1:0] RecoveryHoldReset = 16'd3000;
	localparam logic [CountW-1:0] FactoryHoldReset = 16'd10000;

	localparam logic [CfgIdxW-1:0] REG_BOOT_GUARD = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RECOVERY_HOLD = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_FACTORY_HOLD = 2'd2;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_RECOVERY = 2'd1,
		ACT_FACTORY = 2'd2
	} action_t;

	typedef struct packed {
		logic [CountW-1:0] boot_guard;
		logic [CountW-1:0] recovery_hold;
		logic [CountW-1:0] factory_hold;
	} cfg_t;

	typedef struct packed {
		logic [CountW-1:0] boot_count;
		logic release_seen;
		logic held;
		logic [CountW-1:0] hold_count;
		logic recovery_flag;
		logic factory_flag;
	} state_t;

endpackage

`default_nettype wire

// File: src/lprd_step.sv
`default_nettype none

module lprd_step (
	input wire lprd_pkg::cfg_t cfg,
	input wire lprd_pkg::state_t cur,
	input wire logic button_down,
	output lprd_pkg::state_t nxt,
	output lprd_pkg::action_t action
);

	logic rel_seen;

	always_comb begin
		nxt = cur;
		action = lprd_pkg::ACT_NONE;
		rel_seen = cur.release_seen | ~button_down;
		if (cur.boot_count < cfg.boot_guard) begin
			// still inside the boot guard window: count and ignore the button
			nxt.boot_count = cur.boot_count + 1'b1;
		end else begin
			nxt.release_seen = rel_seen;
			if (rel_seen) begin
				if (button_down && !cur.held) begin
					nxt.held = 1'b1;
					nxt.hold_count = '0;
					nxt.recovery_flag = 1'b0;
					nxt.factory_flag = 1'b0;
				end else if (button_down && cur.held) begin
					if (cur.hold_count != lprd_pkg::CountMax) begin
						nxt.hold_count = cur.hold_count + 1'b1;
					end
				end else if (!button_down && cur.held) begin
					nxt.held = 1'b0;
					if (cur.factory_flag) begin
						action = lprd_pkg::ACT_FACTORY;
					end else if (cur.recovery_flag) begin
						action = lprd_pkg::ACT_RECOVERY;
					end
				end
				if (nxt.held) begin
					nxt.recovery_flag = nxt.recovery_flag | (nxt.hold_count >= cfg.recovery_hold);
					nxt.factory_flag = nxt.factory_flag | (nxt.hold_count >= cfg.factory_hold);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/long_press_reset_detector_unit.sv
`default_nettype none

// Long-press button detector. Each input transfer is one timebase tick carrying the
// sampled button level; each tick yields exactly one result transfer with the release
// action and the current armed/press flags. The button is ignored for boot_guard_ticks
// ticks after reset, and a press only counts once a release has been seen. The state
// update is a single compare-and-count step between the state registers and the
// result register, so a new tick is accepted every cycle while the result register
// is empty or being taken. Write the configuration
// registers only while no tick is in flight.
module long_press_reset_detector_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic button_down,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] action,
	output logic recovery_armed,
	output logic factory_armed,
	output logic press_active,
	input wire logic cfg_we,
	input wire logic [lprd_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [lprd_pkg::CountW-1:0] cfg_data
);

	lprd_pkg::cfg_t cfg_q;
	lprd_pkg::state_t state_q;
	lprd_pkg::state_t state_nxt;
	lprd_pkg::action_t act_nxt;
	logic out_valid_q;
	logic [1:0] action_q;
	logic recovery_q;
	logic factory_q;
	logic press_q;
	logic in_xfer;

	assign in_ready = ~out_valid_q | out_ready;
	assign in_xfer = in_valid & in_ready;

	lprd_step u_step (
		.cfg(cfg_q),
		.cur(state_q),
		.button_down(button_down),
		.nxt(state_nxt),
		.action(act_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_guard <= lprd_pkg::BootGuardReset;
			cfg_q.recovery_hold <= lprd_pkg::RecoveryHoldReset;
			cfg_q.factory_hold <= lprd_pkg::FactoryHoldReset;
		end else if (cfg_we) begin
			case (cfg_index)
				lprd_pkg::REG_BOOT_GUARD: cfg_q.boot_guard <= cfg_data;
				lprd_pkg::REG_RECOVERY_HOLD: cfg_q.recovery_hold <= cfg_data;
				lprd_pkg::REG_FACTORY_HOLD: cfg_q.factory_hold <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// hold the result until the consumer takes it
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q <= act_nxt;
			recovery_q <= state_nxt.recovery_flag;
			factory_q <= state_nxt.factory_flag;
			press_q <= state_nxt.held;
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign recovery_armed = recovery_q;
	assign factory_armed = factory_q;
	assign press_active = press_q;

endmodule

`default_nettype wire

// File: src/lprd_checker.sv
`default_nettype none

module lprd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] action,
	input wire logic factory_armed,
	input wire logic press_active
);

	// every accepted tick shows up as a result in the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(press_active))
		else $error("stalled result changed");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= lprd_pkg::ACT_FACTORY)
		else $error("illegal action code");

	// a release action always ends the press
	a_action_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != lprd_pkg::ACT_NONE |-> !press_active)
		else $error("action reported while press still active");

	// factory action only with factory flag kept after release
	a_factory_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == lprd_pkg::ACT_FACTORY |-> factory_armed)
		else $error("factory action without factory flag");

endmodule

bind long_press_reset_detector_unit lprd_checker u_lprd_checker (.*);

`default_nettype wire

// File: tb/long_press_reset_detector_unit_tb.sv
`default_nettype none

module long_press_reset_detector_unit_tb;

	localparam int unsigned QuietLimit = 2000;
	localparam int unsigned HoldOffCycles = 300;
	localparam int unsigned RandomPhases = 6;
	localparam int unsigned PhaseTicks = 280;
	localparam logic [lprd_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

	typedef logic [lprd_pkg::CountW-1:0] count_t;

	typedef struct packed {
		lprd_pkg::action_t action;
		logic recovery_armed;
		logic factory_armed;
		logic press_active;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic button_down = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] action;
	logic recovery_armed;
	logic factory_armed;
	logic press_active;
	logic cfg_we = 1'b0;
	logic [lprd_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [lprd_pkg::CountW-1:0] cfg_data = '0;

	long_press_reset_detector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_down(button_down),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.recovery_armed(recovery_armed),
		.factory_armed(factory_armed),
		.press_active(press_active),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the detector: thresholds and counters as the block should hold them.
	lprd_pkg::cfg_t thresholds = '{boot_guard: lprd_pkg::BootGuardReset,
		recovery_hold: lprd_pkg::RecoveryHoldReset,
		factory_hold: lprd_pkg::FactoryHoldReset};
	lprd_pkg::state_t det = '0;

	logic tick_q[$];
	tick_result_t release_q[$];
	tick_result_t want;
	logic next_level;

	int unsigned send_gap_max = 0;
	int unsigned take_gap_max = 0;
	int unsigned send_wait = 0;
	int unsigned take_wait = 0;
	int unsigned hold_left = 0;
	int unsigned pressure_at = 0;
	int unsigned ticks_queued = 0;
	int unsigned ticks_sent = 0;
	int unsigned results_seen = 0;
	int unsigned recovery_releases = 0;
	int unsigned factory_releases = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	function automatic tick_result_t detect_tick(logic pressed);
		tick_result_t r;
		r.action = lprd_pkg::ACT_NONE;
		if (det.boot_count < thresholds.boot_guard) begin
			det.boot_count = det.boot_count + 1'b1;
		end else begin
			if (!pressed) begin
				det.release_seen = 1'b1;
			end
			if (det.release_seen) begin
				if (pressed && !det.held) begin
					det.held = 1'b1;
					det.hold_count = '0;
					det.recovery_flag = 1'b0;
					det.factory_flag = 1'b0;
				end else if (pressed) begin
					if (det.hold_count != lprd_pkg::CountMax) begin
						det.hold_count = det.hold_count + 1'b1;
					end
				end else if (det.held) begin
					det.held = 1'b0;
					if (det.factory_flag) begin
						r.action = lprd_pkg::ACT_FACTORY;
					end else if (det.recovery_flag) begin
						r.action = lprd_pkg::ACT_RECOVERY;
					end
				end
				if (det.held) begin
					if (det.hold_count >= thresholds.recovery_hold) begin
						det.recovery_flag = 1'b1;
					end
					if (det.hold_count >= thresholds.factory_hold) begin
						det.factory_flag = 1'b1;
					end
				end
			end
		end
		r.recovery_armed = det.recovery_flag;
		r.factory_armed = det.factory_flag;
		r.press_active = det.held;
		return r;
	endfunction

	// Sender: one tick per transfer, with a drawn wait before each new tick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				release_q.push_back(detect_tick(button_down));
				ticks_sent++;
				send_wait = $urandom_range(0, send_gap_max);
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					next_level = tick_q.pop_front();
					in_valid <= 1'b1;
					button_down <= next_level;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (release_q.size() == 0) begin
					$error("result with nothing pending: action %0d", action);
					mismatches++;
				end else begin
					want = release_q.pop_front();
					if (action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, action);
						mismatches++;
					end
					if (recovery_armed !== want.recovery_armed) begin
						$error("recovery_armed: expected %0d, got %0d",
							want.recovery_armed, recovery_armed);
						mismatches++;
					end
					if (factory_armed !== want.factory_armed) begin
						$error("factory_armed: expected %0d, got %0d",
							want.factory_armed, factory_armed);
						mismatches++;
					end
					if (press_active !== want.press_active) begin
						$error("press_active: expected %0d, got %0d",
							want.press_active, press_active);
						mismatches++;
					end
				end
				if (action == lprd_pkg::ACT_RECOVERY) begin
					recovery_releases++;
				end
				if (action == lprd_pkg::ACT_FACTORY) begin
					factory_releases++;
				end
				results_seen++;
				take_wait = $urandom_range(0, take_gap_max);
				if (results_seen == pressure_at) begin
					hold_left = HoldOffCycles;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (take_wait > 0) begin
				take_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles == QuietLimit) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	task automatic push_level(logic level, int unsigned count);
		repeat (count) begin
			tick_q.push_back(level);
			ticks_queued++;
		end
	endtask

	task automatic write_reg(logic [lprd_pkg::CfgIdxW-1:0] idx,
		logic [lprd_pkg::CountW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lprd_pkg::REG_BOOT_GUARD: thresholds.boot_guard = value;
			lprd_pkg::REG_RECOVERY_HOLD: thresholds.recovery_hold = value;
			lprd_pkg::REG_FACTORY_HOLD: thresholds.factory_hold = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Wait until every tick is transferred and every result checked, then settle.
	task automatic drain();
		do begin
			@(negedge clk);
		end while (ticks_sent != ticks_queued || release_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [lprd_pkg::CountW-1:0] guard_val;
		logic [lprd_pkg::CountW-1:0] rec_val;
		logic [lprd_pkg::CountW-1:0] fac_val;
		int unsigned start_ticks;
		int unsigned hi;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Inside the reset guard every level is ignored.
		repeat (20) push_level(1'($urandom_range(0, 1)), 1);
		drain();

		// Reopen the guard for a few ticks, zero recovery threshold, short factory hold.
		send_gap_max = 19;
		take_gap_max = 19;
		write_reg(lprd_pkg::REG_BOOT_GUARD, det.boot_count + 16'd3);
		write_reg(lprd_pkg::REG_RECOVERY_HOLD, 16'd0);
		write_reg(lprd_pkg::REG_FACTORY_HOLD, 16'd2);
		push_level(1'b1, 3);
		push_level(1'b1, 1);
		push_level(1'b0, 2);
		push_level(1'b1, 4);
		push_level(1'b0, 1);
		push_level(1'b1, 1);
		push_level(1'b0, 1);
		drain();
		write_reg(RegUnused, 16'hFFFF);
		push_level(1'b1, 3);
		push_level(1'b0, 1);
		drain();

		// Widest guard, then widest thresholds with a long press that never arms.
		write_reg(lprd_pkg::REG_BOOT_GUARD, 16'hFFFF);
		repeat (30) push_level(1'($urandom_range(0, 1)), 1);
		drain();
		send_gap_max = 0;
		take_gap_max = 0;
		write_reg(lprd_pkg::REG_BOOT_GUARD, 16'd0);
		write_reg(lprd_pkg::REG_RECOVERY_HOLD, 16'hFFFF);
		write_reg(lprd_pkg::REG_FACTORY_HOLD, 16'hFFFF);
		push_level(1'b1, 60);
		push_level(1'b0, 1);
		drain();

		for (int p = 0; p < RandomPhases; p++) begin
			send_gap_max = (p % 3 == 2) ? 0 : 19;
			take_gap_max = (p % 3 == 1) ? 0 : 19;
			fac_val = count_t'($urandom_range(0, 24));
			rec_val = (p == 3) ? count_t'(fac_val + $urandom_range(1, 8))
				: count_t'($urandom_range(0, 12));
			guard_val = $urandom_range(0, 1) ? count_t'(det.boot_count + $urandom_range(0, 6))
				: count_t'($urandom_range(0, 4095));
			write_reg(lprd_pkg::REG_BOOT_GUARD, guard_val);
			write_reg(lprd_pkg::REG_RECOVERY_HOLD, rec_val);
			write_reg(lprd_pkg::REG_FACTORY_HOLD, fac_val);
			if (p % 3 == 1) begin
				pressure_at = results_seen + 40;
			end
			hi = 32'((rec_val > fac_val) ? rec_val : fac_val) + 3;
			start_ticks = ticks_queued;
			while (ticks_queued - start_ticks < PhaseTicks) begin
				if ($urandom_range(0, 9) < 8) begin
					push_level(1'b1, $urandom_range(1, hi));
					push_level(1'b0, $urandom_range(1, 4));
				end else begin
					repeat ($urandom_range(1, 6)) push_level(1'($urandom_range(0, 1)), 1);
				end
			end
			drain();
		end

		$display("Checked %0d ticks over %0d register writes, including guard reopen,",
			results_seen, reg_writes);
		$display("zero and full-scale thresholds; %0d recovery and %0d factory releases.",
			recovery_releases, factory_releases);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/lprd_pkg.sv
src/lprd_step.sv
src/long_press_reset_detector_unit.sv
src/lprd_checker.sv
tb/long_press_reset_detector_unit_tb.sv
